FILE: rtl/bf_pkg.sv
// ----------------------------------------------------------------------------
// bf_pkg
// Shared types and constants of the double-hashing Bloom filter: request and
// result layouts, configuration register indexes, FNV-1a constants.
// ----------------------------------------------------------------------------
package bf_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_BITS = 3'd0,
        CFG_PROBE_COUNT = 3'd1,
        CFG_FIRST_SEED  = 3'd2,
        CFG_SECOND_SEED = 3'd3
    } cfg_reg_e;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [63:0] FNV_BASIS        = 64'hCBF2_9CE4_8422_2325;
    localparam int unsigned FNV_PRIME_SHIFT  = 40;
    localparam logic [8:0]  FNV_PRIME_LOW    = 9'h1B3;

    localparam logic [16:0] FILTER_BITS_RESET = 17'd65536;
    localparam logic [4:0]  PROBE_COUNT_RESET = 5'd7;
    localparam logic [31:0] FIRST_SEED_RESET  = 32'h811C_9DC5;
    localparam logic [31:0] SECOND_SEED_RESET = 32'h0100_0193;

    localparam logic [16:0] FILTER_BITS_MIN = 17'd64;

    typedef struct packed {
        logic       action;
        logic [7:0] key_byte;
        logic       key_last;
    } bf_req_t;

    typedef struct packed {
        logic        done_action;
        logic        maybe_present;
        logic [31:0] items_added;
    } bf_res_t;

    typedef struct packed {
        logic        load_first;
        logic        load_second;
        logic [31:0] value;
    } hash_load_t;

endpackage

FILE: rtl/bloom_filter_fnv_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash
// Bloom filter over byte-streamed keys with two seeded FNV-1a hashes and
// double-hashed probe indices into a word-wide bit store.
//
//   channel   handshake              payload               direction
//   request   start / busy           req (bf_req_t)        in
//   result    done strobe, 1 cycle   result (bf_res_t)     out
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data   in
//
// A non-final key byte only advances the hashes and leaves busy low. A final
// byte starts the probes: each probe runs the shared remainder unit, then
// one bit-store read and one check/write step.
// A query ends at the first clear bit. After reset the store is swept to
// zero, all STORE_WORDS words (1024 at the default size), with busy high.
// The result strobe cannot be held off; config writes are always ready.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash #(
    parameter int unsigned MAX_BITS   = 65536,
    parameter int unsigned MAX_PROBES = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bf_pkg::bf_req_t                    req,
    output logic                               done,
    output bf_pkg::bf_res_t                    result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    localparam int unsigned STEP_BITS   = 4;
    localparam int unsigned MOD_W       = $clog2(MAX_BITS + 1);
    localparam int unsigned CMP_W       = (MOD_W > 17) ? MOD_W : 17;
    localparam int unsigned STORE_WORDS = (MAX_BITS + 63) / 64;
    localparam int unsigned ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int unsigned PRB_W       = (MAX_PROBES > 1) ? $clog2(MAX_PROBES + 1) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;

    logic [16:0]       filter_bits_reg;
    logic [4:0]        probe_count_reg;
    logic [31:0]       first_seed_reg;
    logic [31:0]       second_seed_reg;

    logic [63:0]       acc_reg;
    logic [63:0]       step_reg;
    logic              action_reg;
    logic [PRB_W-1:0]  probe_idx_reg;
    logic [ADDR_W-1:0] word_reg;
    logic [5:0]        bitpos_reg;
    logic [31:0]       count_reg;
    logic              done_reg;
    bf_pkg::bf_res_t   result_reg;

    logic              accept;
    logic              cfg_we;
    bf_pkg::hash_load_t hash_load;
    logic [63:0]       first_next;
    logic [63:0]       second_next;

    logic [CMP_W-1:0]  bits_wide;
    logic [MOD_W-1:0]  eff_bits;
    logic [5:0]        probes_wide;
    logic [PRB_W-1:0]  eff_probes;

    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [MOD_W-1:0]  div_rem;

    logic              clearing;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [63:0]       rd_data;
    logic              wr_en;
    logic [63:0]       wr_data;

    logic              probe_bit;
    logic              last_probe;
    logic              finish;
    logic [31:0]       count_inc;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign busy      = clearing || (state_reg != S_IDLE);

    assign hash_load.load_first  = cfg_we && (cfg_index == bf_pkg::CFG_FIRST_SEED);
    assign hash_load.load_second = cfg_we && (cfg_index == bf_pkg::CFG_SECOND_SEED);
    assign hash_load.value       = cfg_data;

    always_comb
    begin
        bits_wide = CMP_W'(filter_bits_reg);
        if (filter_bits_reg < bf_pkg::FILTER_BITS_MIN)
        begin
            bits_wide = CMP_W'(bf_pkg::FILTER_BITS_MIN);
        end
        else if (CMP_W'(filter_bits_reg) > CMP_W'(MAX_BITS))
        begin
            bits_wide = CMP_W'(MAX_BITS);
        end
        eff_bits = MOD_W'(bits_wide);

        probes_wide = {1'b0, probe_count_reg};
        if (probe_count_reg == 5'd0)
        begin
            probes_wide = 6'd1;
        end
        else if (probes_wide > 6'(MAX_PROBES))
        begin
            probes_wide = 6'(MAX_PROBES);
        end
        eff_probes = PRB_W'(probes_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= bf_pkg::FILTER_BITS_RESET;
            probe_count_reg <= bf_pkg::PROBE_COUNT_RESET;
            first_seed_reg  <= bf_pkg::FIRST_SEED_RESET;
            second_seed_reg <= bf_pkg::SECOND_SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bf_pkg::CFG_FILTER_BITS: filter_bits_reg <= cfg_data[16:0];
                bf_pkg::CFG_PROBE_COUNT: probe_count_reg <= cfg_data[4:0];
                bf_pkg::CFG_FIRST_SEED:  first_seed_reg  <= cfg_data;
                bf_pkg::CFG_SECOND_SEED: second_seed_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    bf_hash u_hash (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (accept),
        .key_byte    (req.key_byte),
        .key_last    (req.key_last),
        .load        (hash_load),
        .first_seed  (first_seed_reg),
        .second_seed (second_seed_reg),
        .first_next  (first_next),
        .second_next (second_next)
    );

    bf_mod #(
        .MOD_W     (MOD_W),
        .STEP_BITS (STEP_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (acc_reg),
        .modulus   (eff_bits),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    bf_store #(
        .WORDS  (STORE_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (word_reg),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    assign rd_en      = (state_reg == S_WAIT) && div_done;
    assign rd_addr    = ADDR_W'(div_rem >> 6);
    assign probe_bit  = rd_data[bitpos_reg];
    assign wr_en      = (state_reg == S_CHECK) && (action_reg == bf_pkg::ACT_ADD);
    assign wr_data    = rd_data | (64'd1 << bitpos_reg);
    assign last_probe = (PRB_W'(probe_idx_reg + 1'b1) == eff_probes);
    assign finish     = (state_reg == S_CHECK)
                     && (last_probe || ((action_reg == bf_pkg::ACT_QUERY) && !probe_bit));
    assign div_start  = (state_reg == S_START) || ((state_reg == S_CHECK) && !finish);
    assign count_inc  = (count_reg == 32'hFFFF_FFFF) ? count_reg : 32'(count_reg + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.key_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = finish ? S_IDLE : S_WAIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= 32'd0;
            probe_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if ((state_reg == S_IDLE) && accept && req.key_last)
            begin
                probe_idx_reg <= '0;
            end
            else if ((state_reg == S_CHECK) && !finish)
            begin
                probe_idx_reg <= PRB_W'(probe_idx_reg + 1'b1);
            end
            if (finish && (action_reg == bf_pkg::ACT_ADD))
            begin
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && accept && req.key_last)
        begin
            action_reg <= req.action;
            acc_reg    <= first_next;
            step_reg   <= second_next;
        end
        else if (rd_en)
        begin
            acc_reg    <= acc_reg + step_reg;
            word_reg   <= rd_addr;
            bitpos_reg <= div_rem[5:0];
        end
        if (finish)
        begin
            result_reg.done_action   <= action_reg;
            result_reg.maybe_present <= (action_reg == bf_pkg::ACT_ADD) || probe_bit;
            result_reg.items_added   <= (action_reg == bf_pkg::ACT_ADD) ? count_inc
                                                                         : count_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_CHECK))
        else $error("result strobe without a finished probe check");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("remainder unit running while idle");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.items_added == count_reg))
        else $error("reported count differs from counter");

    a_add_present: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.done_action == bf_pkg::ACT_ADD)) |-> result.maybe_present)
        else $error("add reported as absent");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (probe_idx_reg < eff_probes))
        else $error("probe index past probe count");

endmodule

FILE: rtl/bf_hash.sv
// ----------------------------------------------------------------------------
// bf_hash
// Two seeded 64-bit FNV-1a hash accumulators, advanced one key byte per
// request and reloaded from their seeds at the end of each key or on a seed write.
// ----------------------------------------------------------------------------
module bf_hash (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_en,
    input  logic [7:0]         key_byte,
    input  logic               key_last,
    input  bf_pkg::hash_load_t load,
    input  logic [31:0]        first_seed,
    input  logic [31:0]        second_seed,
    output logic [63:0]        first_next,
    output logic [63:0]        second_next
);

    logic [63:0] first_hash_reg;
    logic [63:0] second_hash_reg;
    logic [63:0] first_mix;
    logic [63:0] second_mix;

    assign first_mix  = first_hash_reg ^ {56'd0, key_byte};
    assign second_mix = second_hash_reg ^ {56'd0, key_byte};

    assign first_next  = (first_mix << bf_pkg::FNV_PRIME_SHIFT)
                       + first_mix * {55'd0, bf_pkg::FNV_PRIME_LOW};
    assign second_next = (second_mix << bf_pkg::FNV_PRIME_SHIFT)
                       + second_mix * {55'd0, bf_pkg::FNV_PRIME_LOW};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_hash_reg  <= {32'd0, bf_pkg::FIRST_SEED_RESET} ^ bf_pkg::FNV_BASIS;
            second_hash_reg <= {32'd0, bf_pkg::SECOND_SEED_RESET} ^ bf_pkg::FNV_BASIS;
        end
        else
        begin
            if (load.load_first)
            begin
                first_hash_reg <= {32'd0, load.value} ^ bf_pkg::FNV_BASIS;
            end
            else if (byte_en)
            begin
                first_hash_reg <= key_last
                    ? ({32'd0, first_seed} ^ bf_pkg::FNV_BASIS) : first_next;
            end
            if (load.load_second)
            begin
                second_hash_reg <= {32'd0, load.value} ^ bf_pkg::FNV_BASIS;
            end
            else if (byte_en)
            begin
                second_hash_reg <= key_last
                    ? ({32'd0, second_seed} ^ bf_pkg::FNV_BASIS) : second_next;
            end
        end
    end

endmodule

FILE: rtl/bf_mod.sv
// ----------------------------------------------------------------------------
// bf_mod
// Iterative remainder unit: 64-bit dividend modulo a narrow MOD_W-bit modulus,
// STEP_BITS quotient bits per cycle by shift and conditional subtract.
// ----------------------------------------------------------------------------
module bf_mod #(
    parameter int unsigned MOD_W     = 17,
    parameter int unsigned STEP_BITS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [MOD_W-1:0] modulus,
    output logic             busy,
    output logic             done,
    output logic [MOD_W-1:0] remainder
);

    localparam int unsigned STEPS = 64 / STEP_BITS;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [63:0]      quot_reg;
    logic [63:0]      quot_next;
    logic [MOD_W-1:0] rem_reg;
    logic [MOD_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        logic [MOD_W:0] r;
        logic [63:0]    q;
        r = {1'b0, rem_reg};
        q = quot_reg;
        for (int s = 0; s < int'(STEP_BITS); s++)
        begin
            r = {r[MOD_W-1:0], q[63]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, modulus})
            begin
                r = r - {1'b0, modulus};
            end
        end
        rem_next  = r[MOD_W-1:0];
        quot_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/bf_store.sv
// ----------------------------------------------------------------------------
// bf_store
// Bit store of 64-bit words with one write and one registered read port,
// swept to zero one word per cycle after reset.
// ----------------------------------------------------------------------------
module bf_store #(
    parameter int unsigned WORDS  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [63:0]       wr_data,
    output logic              clearing
);

    logic [63:0]       mem [WORDS];
    logic [63:0]       rd_data_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [63:0]       mem_wdata;

    assign mem_we    = clearing_reg || wr_en;
    assign mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clearing_reg ? 64'd0 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= ADDR_W'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == ADDR_W'(WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule
